/* sv/julia_escape_time_pixel_defines.svh */
// Assertion macros for the Julia escape-time pixel block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JET_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jet assertion failed");

// Next-cycle implication, checked outside reset.
`define JET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jet assertion failed");

`endif

/* sv/jet_pkg.sv */
// Shared types, widths and constants for the Julia escape-time pixel block.
// No dependencies; every other file but the defines header imports this package.
`timescale 1ns / 1ps

package jet_pkg;

	localparam int FRAC_BITS_DEF = 13;

	localparam int START_W    = 17;
	localparam int C_W        = 16;
	localparam int LIMIT_W    = 8;
	localparam int BASE_W     = 8;
	localparam int GAIN_W     = 22;
	localparam int COLOR_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam int CNT_W      = LIMIT_W + 1;

	localparam logic signed [C_W-1:0]    C_REAL_RST = '0;
	localparam logic signed [C_W-1:0]    C_IMAG_RST = '0;
	localparam logic [LIMIT_W-1:0]       LIMIT_RST  = LIMIT_W'(25);
	localparam logic [BASE_W-1:0]        BASE_RST   = BASE_W'(80);
	localparam logic signed [GAIN_W-1:0] GAIN_RST   = GAIN_W'(57344);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_REAL     = 3'd0,
		REG_C_IMAG     = 3'd1,
		REG_ITER_LIMIT = 3'd2,
		REG_COLOR_BASE = 3'd3,
		REG_COLOR_GAIN = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_TEST,
		ST_GAIN,
		ST_FINISH
	} jet_state_t;

	typedef enum logic [1:0] {
		OP_RR,
		OP_II,
		OP_RI,
		OP_GAIN
	} mul_op_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		mul_op_t mul_op;
		logic    mul_en;
		logic    load_z;
		logic    cap_rr;
		logic    cap_ii;
		logic    dec;
		logic    update;
		logic    set_esc;
		logic    load_out;
	} jet_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic cnt_zero;
		logic mag_big;
	} jet_stat_t;

endpackage

/* sv/jet_in_if.sv */
// Input channel carrying one pixel start point per item.
// Depends on jet_pkg for field widths.
`timescale 1ns / 1ps

interface jet_in_if import jet_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [START_W-1:0] start_re;
	logic signed [START_W-1:0] start_im;

	modport source (output valid, output start_re, output start_im, input ready);
	modport sink (input valid, input start_re, input start_im, output ready);
endinterface

/* sv/jet_out_if.sv */
// Output channel carrying one color index and escape flag per item.
// Depends on jet_pkg for field widths.
`timescale 1ns / 1ps

interface jet_out_if import jet_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] color_index;
	logic               escaped;

	modport source (output valid, output color_index, output escaped, input ready);
	modport sink (input valid, input color_index, input escaped, output ready);
endinterface

/* sv/jet_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on jet_pkg for field widths.
`timescale 1ns / 1ps

interface jet_cfg_if import jet_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/jet_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on jet_pkg only through the common import convention.
`timescale 1ns / 1ps

module jet_mul import jet_pkg::*; #(
	parameter int AW = 17,
	parameter int BW = 22
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] prod
);

	logic signed [AW+BW-1:0] prod_q;

	// The product holds while the unit is not issued, so a result may wait.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

/* sv/jet_ctrl.sv */
// Sequencer for the escape-time iteration: schedules the shared multiplier.
// Depends on jet_pkg for the state, command and status types.
`timescale 1ns / 1ps

module jet_ctrl import jet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	input  jet_stat_t stat,
	output logic      in_ready,
	output jet_cmd_t  cmd
);

	jet_state_t state_q;
	jet_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL_RR;
				end
			end
			ST_MUL_RR: state_d = ST_MUL_II;
			ST_MUL_II: state_d = ST_MUL_RI;
			ST_MUL_RI: state_d = ST_TEST;
			ST_TEST: begin
				if (stat.cnt_zero || stat.mag_big) begin
					state_d = ST_GAIN;
				end else begin
					state_d = ST_MUL_RR;
				end
			end
			ST_GAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.load_z = in_valid;
			end
			ST_MUL_RR: begin
				cmd.mul_op = OP_RR;
				cmd.mul_en = 1'b1;
			end
			ST_MUL_II: begin
				cmd.mul_op = OP_II;
				cmd.mul_en = 1'b1;
				cmd.cap_rr = 1'b1;
			end
			ST_MUL_RI: begin
				cmd.mul_op = OP_RI;
				cmd.mul_en = 1'b1;
				cmd.cap_ii = 1'b1;
			end
			ST_TEST: begin
				// The countdown is tested before the magnitude, as in the iteration rule.
				cmd.dec     = 1'b1;
				cmd.set_esc = !stat.cnt_zero && stat.mag_big;
				cmd.update  = !stat.cnt_zero && !stat.mag_big;
			end
			ST_GAIN: begin
				cmd.mul_op = OP_GAIN;
				cmd.mul_en = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* sv/julia_escape_time_pixel.sv */
// Julia escape-time pixel: iterates z = z*z + c on one start point per item.
// Each step issues the one shared multiplier for zr*zr, zi*zi and zr*zi in turn, then tests;
// a final multiply scales the count by the gain. A new start point is taken only once the
// last item has moved into the output register, so items never overlap in the block.
// Reset (arst_n low) restores register defaults and empties the output register.
// Depends on jet_pkg, the channel interfaces, jet_mul, jet_ctrl and the defines header.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_defines.svh"

module julia_escape_time_pixel import jet_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	jet_in_if.sink    pix_in,
	jet_out_if.source pix_out,
	jet_cfg_if.sink   cfg
);

	// The iterate stays inside FRAC_BITS+4 bits once a step has run.
	localparam int ZW = (FRAC_BITS + 4 > START_W) ? FRAC_BITS + 4 : START_W;
	localparam int AW = ZW;
	localparam int BW = (ZW > GAIN_W) ? ZW : GAIN_W;
	localparam int PW = AW + BW;
	localparam logic [PW:0] MAG_LIMIT = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

	logic signed [C_W-1:0]    c_real_q;
	logic signed [C_W-1:0]    c_imag_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic [BASE_W-1:0]        base_q;
	logic signed [GAIN_W-1:0] gain_q;

	logic signed [ZW-1:0]    zr_q;
	logic signed [ZW-1:0]    zi_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic                    esc_q;
	logic signed [PW-1:0]    rr_q;
	logic signed [PW-1:0]    ii_q;

	logic               out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic               out_esc_q;

	jet_cmd_t  cmd;
	jet_stat_t stat;
	logic      out_free;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;

	logic [PW:0]          mag_sum;
	logic signed [PW:0]   re_diff;
	logic signed [PW:0]   re_sum;
	logic signed [PW-1:0] im_sum;
	logic signed [PW-1:0] scaled;

	// Configuration registers; writes beyond the last register are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q <= C_REAL_RST;
			c_imag_q <= C_IMAG_RST;
			limit_q  <= LIMIT_RST;
			base_q   <= BASE_RST;
			gain_q   <= GAIN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_C_REAL:     c_real_q <= cfg.data[C_W-1:0];
				REG_C_IMAG:     c_imag_q <= cfg.data[C_W-1:0];
				REG_ITER_LIMIT: limit_q  <= cfg.data[LIMIT_W-1:0];
				REG_COLOR_BASE: base_q   <= cfg.data[BASE_W-1:0];
				REG_COLOR_GAIN: gain_q   <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	jet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (pix_in.ready),
		.cmd      (cmd)
	);

	always_comb begin
		unique case (cmd.mul_op)
			OP_RR: begin
				mul_a = zr_q;
				mul_b = BW'(zr_q);
			end
			OP_II: begin
				mul_a = zi_q;
				mul_b = BW'(zi_q);
			end
			OP_RI: begin
				mul_a = zr_q;
				mul_b = BW'(zi_q);
			end
			OP_GAIN: begin
				mul_a = AW'(cnt_q);
				mul_b = BW'(gain_q);
			end
			default: begin
				mul_a = zr_q;
				mul_b = BW'(zr_q);
			end
		endcase
	end

	jet_mul #(
		.AW (AW),
		.BW (BW)
	) u_mul (
		.clk  (clk),
		.en   (cmd.mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Squares are non-negative, so their sum compares as unsigned.
	assign mag_sum = {1'b0, rr_q} + {1'b0, ii_q};
	assign re_diff = (PW + 1)'(rr_q) - (PW + 1)'(ii_q);
	assign re_sum  = (re_diff >>> FRAC_BITS) + (PW + 1)'(c_real_q);
	// Doubling the cross product folds into a shift one place shorter.
	assign im_sum  = (prod >>> (FRAC_BITS - 1)) + PW'(c_imag_q);
	assign scaled  = prod >>> FRAC_BITS;

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.mag_big  = (mag_sum >= MAG_LIMIT);

	always_ff @(posedge clk) begin
		if (cmd.load_z) begin
			zr_q  <= ZW'(pix_in.start_re);
			zi_q  <= ZW'(pix_in.start_im);
			cnt_q <= CNT_W'(limit_q);
			esc_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				zr_q <= re_sum[ZW-1:0];
				zi_q <= im_sum[ZW-1:0];
			end
			if (cmd.dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.set_esc) begin
				esc_q <= 1'b1;
			end
		end
		if (cmd.cap_rr) begin
			rr_q <= prod;
		end
		if (cmd.cap_ii) begin
			ii_q <= prod;
		end
	end

	// Output register lets a finished item wait while the sink stalls.
	assign out_free = !out_valid_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			color_q   <= scaled[COLOR_W-1:0] + base_q;
			out_esc_q <= esc_q;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.color_index = color_q;
	assign pix_out.escaped     = out_esc_q;

	`JET_ASSERT_NEXT(a_busy_after_accept, pix_in.valid && pix_in.ready, !pix_in.ready)
	`JET_ASSERT_NOW(a_load_only_when_free, cmd.load_out, !out_valid_q || pix_out.ready)
	`JET_ASSERT_NEXT(a_expired_goes_to_gain, cmd.dec && stat.cnt_zero,
		cmd.mul_en && (cmd.mul_op == OP_GAIN) && !esc_q)
	`JET_ASSERT_NOW(a_no_update_when_big, cmd.update, !stat.mag_big && !stat.cnt_zero)

endmodule

/* test/julia_escape_time_pixel_tb.sv */
// Self-checking testbench for julia_escape_time_pixel: directed corner points, then random phases.
// A scoreboard class predicts each color index and escape flag; it depends on jet_pkg and the
// channel interfaces.
`timescale 1ns / 1ps

module julia_escape_time_pixel_tb;
	import jet_pkg::*;

	localparam int FRAC            = FRAC_BITS_DEF;
	localparam int WATCHDOG_CYCLES = 20000;
	localparam int HOLD_CYCLES     = 2000;
	localparam int PHASE_ITEMS     = 75;
	localparam int PHASES          = 8;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               esc;
	} pixel_res_t;

	class pixel_scoreboard;
		logic signed [C_W-1:0]    c_re;
		logic signed [C_W-1:0]    c_im;
		logic [LIMIT_W-1:0]       limit;
		logic [BASE_W-1:0]        base;
		logic signed [GAIN_W-1:0] gain;
		pixel_res_t               pending[$];
		int                       errors;

		function new();
			c_re   = C_REAL_RST;
			c_im   = C_IMAG_RST;
			limit  = LIMIT_RST;
			base   = BASE_RST;
			gain   = GAIN_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_C_REAL:     c_re  = data[C_W-1:0];
				REG_C_IMAG:     c_im  = data[C_W-1:0];
				REG_ITER_LIMIT: limit = data[LIMIT_W-1:0];
				REG_COLOR_BASE: base  = data[BASE_W-1:0];
				REG_COLOR_GAIN: gain  = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Runs the escape-time loop; the countdown is tested before it is decremented,
		// so an expired countdown leaves the remaining count at -1.
		function pixel_res_t escape_color(logic signed [START_W-1:0] re,
				logic signed [START_W-1:0] im);
			longint     zr;
			longint     zi;
			longint     nr;
			longint     ni;
			longint     remaining;
			longint     scaled;
			longint     radius_sq;
			pixel_res_t res;
			zr        = re;
			zi        = im;
			remaining = limit;
			radius_sq = longint'(4) << (2 * FRAC);
			res.esc   = 1'b0;
			while (1) begin
				if (remaining == 0) begin
					remaining = -1;
					break;
				end
				remaining--;
				if (zr * zr + zi * zi >= radius_sq) begin
					res.esc = 1'b1;
					break;
				end
				nr = ((zr * zr - zi * zi) >>> FRAC) + longint'(c_re);
				ni = ((2 * zr * zi) >>> FRAC) + longint'(c_im);
				zr = nr;
				zi = ni;
			end
			scaled    = (remaining * longint'(gain)) >>> FRAC;
			res.color = COLOR_W'(scaled + longint'(base));
			return res;
		endfunction

		function void take_point(logic signed [START_W-1:0] re, logic signed [START_W-1:0] im);
			pending.push_back(escape_color(re, im));
		endfunction

		function void check_pixel(logic [COLOR_W-1:0] color, logic esc);
			pixel_res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item: color_index %0d escaped %0b", $time, color, esc);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (color !== want.color) begin
				$display("%0t: color_index expected %0d, actual %0d", $time, want.color, color);
				errors++;
			end
			if (esc !== want.esc) begin
				$display("%0t: escaped expected %0b, actual %0b", $time, want.esc, esc);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	jet_in_if  pix_in ();
	jet_out_if pix_out ();
	jet_cfg_if cfg ();

	julia_escape_time_pixel #(
		.FRAC_BITS(FRAC)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.pix_out(pix_out),
		.cfg    (cfg)
	);

	pixel_scoreboard sb = new();

	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int hold_requests = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// All accepted traffic is observed here at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				sb.write_reg(cfg.index, cfg.data);
			if (pix_in.valid && pix_in.ready)
				sb.take_point(pix_in.start_re, pix_in.start_im);
			if (pix_out.valid && pix_out.ready)
				sb.check_pixel(pix_out.color_index, pix_out.escaped);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((cfg.valid && cfg.ready) || (pix_in.valid && pix_in.ready)
					|| (pix_out.valid && pix_out.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen     = 0;
		hold_left     = 0;
		pix_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out.ready = 1'b0;
			end else begin
				pix_out.ready = ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_point(logic signed [START_W-1:0] re, logic signed [START_W-1:0] im);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			pix_in.valid = 1'b0;
		end
		@(negedge clk);
		pix_in.valid    = 1'b1;
		pix_in.start_re = re;
		pix_in.start_im = im;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = data;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Stops offering points and waits until every predicted item has come back.
	task automatic drain();
		@(negedge clk);
		pix_in.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int tx_pct, int rx_pct, bit deep_limit);
		int c_val;
		int lim;
		int gain_val;
		int re;
		int im;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int k = 0; k < 2; k++) begin
			if ($urandom_range(7) == 0)
				c_val = int'($urandom_range(65535)) - 32768;
			else
				c_val = int'($urandom_range(24000)) - 12000;
			write_reg(k == 0 ? REG_C_REAL : REG_C_IMAG, CFG_DATA_W'(c_val));
		end
		if (deep_limit)
			lim = 255;
		else if ($urandom_range(9) == 0)
			lim = 0;
		else
			lim = $urandom_range(1, 48);
		write_reg(REG_ITER_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_COLOR_BASE, CFG_DATA_W'($urandom_range(255)));
		// Half the time the gain spreads the count over a color span; otherwise it is arbitrary.
		if ($urandom_range(1) == 0) begin
			gain_val = (int'($urandom_range(255)) << FRAC) / (lim == 0 ? 1 : lim);
			if ($urandom_range(3) == 0)
				gain_val = -gain_val;
		end else begin
			gain_val = int'($urandom_range(4194303)) - 2097152;
		end
		write_reg(REG_COLOR_GAIN, CFG_DATA_W'(gain_val));
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(7) == 0) begin
				re = int'($urandom_range(131071)) - 65536;
				im = int'($urandom_range(131071)) - 65536;
			end else begin
				re = int'($urandom_range(40000)) - 20000;
				im = int'($urandom_range(40000)) - 20000;
			end
			send_point(START_W'(re), START_W'(im));
		end
		drain();
	endtask

	initial begin
		int tx_by_mode[4];
		int rx_by_mode[4];
		tx_by_mode      = '{0, 82, 0, 25};
		rx_by_mode      = '{0, 0, 82, 25};
		arst_n          = 1'b0;
		pix_in.valid    = 1'b0;
		pix_in.start_re = '0;
		pix_in.start_im = '0;
		cfg.valid       = 1'b0;
		cfg.index       = '0;
		cfg.data        = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: origin stays put, the radius point escapes at once, then field extremes.
		send_point(17'sd0, 17'sd0);
		send_point(17'sd16384, 17'sd0);
		send_point(17'sd16383, 17'sd0);
		send_point(-17'sd65536, -17'sd65536);
		send_point(17'sd65535, 17'sd65535);
		send_point(17'sd65535, -17'sd65536);
		send_point(-17'sd65536, 17'sd65535);
		drain();

		write_reg(REG_C_REAL, CFG_DATA_W'(32767));
		write_reg(REG_C_IMAG, CFG_DATA_W'(-32768));
		write_reg(REG_ITER_LIMIT, CFG_DATA_W'(255));
		write_reg(REG_COLOR_BASE, CFG_DATA_W'(255));
		write_reg(REG_COLOR_GAIN, CFG_DATA_W'(-2097152));
		send_point(17'sd0, 17'sd0);
		send_point(17'sd1, 17'sd1);
		drain();

		write_reg(REG_C_REAL, CFG_DATA_W'(-32768));
		write_reg(REG_C_IMAG, CFG_DATA_W'(32767));
		write_reg(REG_COLOR_BASE, CFG_DATA_W'(0));
		write_reg(REG_COLOR_GAIN, CFG_DATA_W'(2097151));
		send_point(17'sd0, 17'sd0);
		send_point(-17'sd1, -17'sd1);
		drain();

		// A zero limit takes no step at all, even from a point outside the radius.
		write_reg(REG_ITER_LIMIT, CFG_DATA_W'(0));
		send_point(17'sd0, 17'sd0);
		send_point(17'sd65535, 17'sd0);
		drain();

		// Writes to indexes past the last register must leave every setting alone.
		for (int i = int'(REG_COLOR_GAIN) + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		write_reg(REG_ITER_LIMIT, CFG_DATA_W'(3));
		send_point(17'sd100, -17'sd100);
		drain();

		// A classic bounded constant with the full countdown.
		write_reg(REG_C_REAL, CFG_DATA_W'(-6554));
		write_reg(REG_C_IMAG, CFG_DATA_W'(1278));
		write_reg(REG_ITER_LIMIT, CFG_DATA_W'(255));
		write_reg(REG_COLOR_GAIN, CFG_DATA_W'(8192));
		send_point(17'sd0, 17'sd0);
		send_point(17'sd4096, -17'sd4096);
		send_point(-17'sd12000, 17'sd3000);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			// The first phase starts with a long result hold-off so the input backs up.
			if (p == 0)
				hold_requests++;
			run_phase(tx_by_mode[p % 4], rx_by_mode[p % 4], p == 5);
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/jet_pkg.sv
sv/jet_in_if.sv
sv/jet_out_if.sv
sv/jet_cfg_if.sv
sv/jet_mul.sv
sv/jet_ctrl.sv
sv/julia_escape_time_pixel.sv
test/julia_escape_time_pixel_tb.sv
